// ===== hw/rtl/afsk_bit_demodulator_defines.svh =====
// assertion macros shared by the afsk bit demodulator rtl
// no dependencies; assertions compile out when SYNTH is defined
`ifndef AFSK_BIT_DEMODULATOR_DEFINES_SVH
`define AFSK_BIT_DEMODULATOR_DEFINES_SVH
`ifndef SYNTH
`define AFSKD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("afskd assertion failed");
`define AFSKD_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("afskd assertion failed");
`else
`define AFSKD_ASSERT(lbl, prop)
`define AFSKD_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

// ===== hw/rtl/afskd_pkg.sv =====
// types and constants of the afsk bit demodulator
// no dependencies; used by afskd_ctrl, afskd_dp and the top level
`default_nettype none
package afskd_pkg;

  localparam int DC_WINDOW = 16;
  localparam int DC_SHIFT = 4;
  localparam int WIN_IDX_W = $clog2(DC_WINDOW);
  localparam int SUM_W = 8 + WIN_IDX_W;

  localparam int PHASE_W = 7;
  localparam logic [PHASE_W-1:0] PHASE_STEP = 7'd8;
  localparam logic [PHASE_W-1:0] PHASE_HALF = 7'd32;
  localparam logic [PHASE_W-1:0] PHASE_FULL = 7'd64;

  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FILTER_MODE = 1'b0,
    REG_TEST_MODE   = 1'b1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_MULT,
    ST_FILT,
    ST_COMMIT
  } state_e;

  typedef struct packed {
    logic signed [7:0] sample;
    logic              carrier_detect;
  } in_item_t;

  typedef struct packed {
    logic       bit_valid;
    logic       demod_bit;
    logic       flush_request;
    logic [7:0] peak_volume;
  } out_item_t;

  typedef struct packed {
    logic start;
    logic scan;
    logic mult;
    logic filt;
    logic commit;
  } dp_cmd_t;

  typedef struct packed {
    logic scan_last;
    logic demod_en;
  } dp_status_t;

endpackage
`default_nettype wire

// ===== hw/rtl/afskd_ctrl.sv =====
// sequencing state machine of the afsk bit demodulator
// depends on afskd_pkg and the assertion macro header
`default_nettype none
`include "afsk_bit_demodulator_defines.svh"
module afskd_ctrl (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_stall_o,
  output logic                 out_valid_o,
  input  wire                  out_stall_i,
  input  afskd_pkg::dp_status_t status_i,
  output afskd_pkg::dp_cmd_t   cmd_o
);

  afskd_pkg::state_e state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= afskd_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    case (state_q)
      afskd_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = afskd_pkg::ST_SCAN;
        end
      end
      afskd_pkg::ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (status_i.scan_last) begin
          // skipped demodulation goes straight to the result
          state_d = status_i.demod_en ? afskd_pkg::ST_MULT : afskd_pkg::ST_COMMIT;
        end
      end
      afskd_pkg::ST_MULT: begin
        cmd_o.mult = 1'b1;
        state_d    = afskd_pkg::ST_FILT;
      end
      afskd_pkg::ST_FILT: begin
        cmd_o.filt = 1'b1;
        state_d    = afskd_pkg::ST_COMMIT;
      end
      afskd_pkg::ST_COMMIT: begin
        if (out_free) begin
          cmd_o.commit = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = afskd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = afskd_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

  `AFSKD_ASSERT_ALWAYS(a_cmd_onehot, ($onehot0(cmd_o)))
  `AFSKD_ASSERT(a_accept_starts_scan, (in_valid_i && !in_stall_o |=> state_q == afskd_pkg::ST_SCAN))
  `AFSKD_ASSERT(a_result_from_commit, ($rose(out_valid_o) |-> $past(state_q == afskd_pkg::ST_COMMIT)))
  `AFSKD_ASSERT(a_result_held, (out_valid_o && out_stall_i |=> out_valid_o))

endmodule
`default_nettype wire

// ===== hw/rtl/afskd_dp.sv =====
// datapath: dc window scan, discriminator, iir lowpass, slicer and bit timing
// depends on afskd_pkg; driven by afskd_ctrl commands
`default_nettype none
module afskd_dp (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  afskd_pkg::dp_cmd_t                   cmd_i,
  output afskd_pkg::dp_status_t                status_o,
  input  afskd_pkg::in_item_t                  in_data_i,
  output afskd_pkg::out_item_t                 out_data_o,
  input  wire                                  cfg_we_i,
  input  wire [afskd_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  wire [afskd_pkg::CFG_DATA_W-1:0]      cfg_data_i
);

  localparam int IW = afskd_pkg::WIN_IDX_W;
  localparam int SW = afskd_pkg::SUM_W;
  localparam int PW = afskd_pkg::PHASE_W;

  // persistent demodulator state
  logic [7:0]           win_q [afskd_pkg::DC_WINDOW];
  logic [IW-1:0]        wpos_q;
  logic                 carrier_q;
  logic [7:0]           dly_q [4];
  logic [1:0]           dpos_q;
  logic signed [15:0]   prod_prev_q, prod_cur_q, filt_q;
  logic [7:0]           slice_q;
  logic [PW-1:0]        phase_q;
  logic                 filter_mode_q, test_mode_q;

  // per-item working registers
  logic signed [7:0]    smp_q, cur_q, lo_q, hi_q;
  logic                 cd_q;
  logic signed [SW-1:0] sum_q;
  logic [IW-1:0]        cnt_q;
  afskd_pkg::out_item_t out_q;

  logic signed [7:0]    tap;
  logic signed [7:0]    old;
  logic signed [15:0]   prod;
  logic signed [15:0]   y_new;
  logic signed [SW-1:0] mean_full;
  logic [7:0]           mean8, residual, volume;
  logic [PW-1:0]        ph_nudge, ph_step;
  logic                 bit_due, maj_bit, trans;

  assign tap = $signed(win_q[cnt_q]);
  assign old = $signed(dly_q[dpos_q]);
  assign prod = old * cur_q;

  always_comb begin
    y_new = prod_prev_q + prod_cur_q + (filt_q >>> 1);
    if (!filter_mode_q) begin
      y_new = y_new + (filt_q >>> 3) + (filt_q >>> 5);
    end
  end

  assign mean_full = sum_q >>> afskd_pkg::DC_SHIFT;
  assign mean8     = mean_full[7:0];
  assign residual  = smp_q - mean8;
  assign volume    = hi_q - lo_q;

  // bit timing uses the slice history already shifted in the filter step
  assign trans = slice_q[0] ^ slice_q[1];
  always_comb begin
    ph_nudge = phase_q;
    if (trans) begin
      ph_nudge = (phase_q < afskd_pkg::PHASE_HALF) ? phase_q + PW'(1) : phase_q - PW'(1);
    end
    ph_step = ph_nudge + afskd_pkg::PHASE_STEP;
    bit_due = ph_step >= afskd_pkg::PHASE_FULL;
    maj_bit = slice_q[2:0] inside {3'b111, 3'b110, 3'b101, 3'b011};
  end

  assign status_o.scan_last = cnt_q == IW'(afskd_pkg::DC_WINDOW - 1);
  assign status_o.demod_en  = !test_mode_q && carrier_q;

  // working registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      smp_q <= in_data_i.sample;
      cd_q  <= in_data_i.carrier_detect;
      cnt_q <= '0;
      lo_q  <= 8'sd127;
      hi_q  <= -8'sd128;
      sum_q <= '0;
    end
    if (cmd_i.scan) begin
      if (tap < lo_q) lo_q <= tap;
      if (tap > hi_q) hi_q <= tap;
      sum_q <= sum_q + SW'(tap);
      if (cnt_q == wpos_q) cur_q <= tap;
      cnt_q <= cnt_q + IW'(1);
    end
    if (cmd_i.commit) begin
      out_q.peak_volume   <= volume;
      out_q.flush_request <= !test_mode_q && !carrier_q;
      out_q.bit_valid     <= status_o.demod_en && bit_due;
      out_q.demod_bit     <= status_o.demod_en && bit_due && maj_bit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < afskd_pkg::DC_WINDOW; i++) win_q[i] <= '0;
      for (int i = 0; i < 4; i++) dly_q[i] <= '0;
      wpos_q        <= '0;
      carrier_q     <= 1'b0;
      dpos_q        <= '0;
      prod_prev_q   <= '0;
      prod_cur_q    <= '0;
      filt_q        <= '0;
      slice_q       <= '0;
      phase_q       <= '0;
      filter_mode_q <= 1'b0;
      test_mode_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (afskd_pkg::cfg_reg_e'(cfg_index_i))
          afskd_pkg::REG_FILTER_MODE: filter_mode_q <= cfg_data_i[0];
          afskd_pkg::REG_TEST_MODE:   test_mode_q   <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (cmd_i.mult) begin
        prod_prev_q <= prod_cur_q;
        prod_cur_q  <= prod >>> 2;
      end
      if (cmd_i.filt) begin
        filt_q        <= y_new;
        slice_q       <= {slice_q[6:0], !y_new[15] && (y_new != '0)};
        dly_q[dpos_q] <= cur_q;
        dpos_q        <= dpos_q + 2'd1;
      end
      if (cmd_i.commit) begin
        if (status_o.demod_en) begin
          phase_q <= bit_due ? {1'b0, ph_step[PW-2:0]} : ph_step;
        end
        carrier_q     <= cd_q;
        win_q[wpos_q] <= residual;
        wpos_q <= (wpos_q == IW'(afskd_pkg::DC_WINDOW - 1)) ? '0 : wpos_q + IW'(1);
      end
    end
  end

  assign out_data_o = out_q;

endmodule
`default_nettype wire

// ===== hw/rtl/afsk_bit_demodulator.sv =====
// afsk bit demodulator top level: controller plus datapath, one result per sample
// per sample: scan, mult, filt, commit states; skipped demodulation drops mult and filt
// a sample is taken only in idle after the last commit, paced by the serial 16-entry dc scan
// the output register lets the next sample be accepted while a result waits
// async active-low reset clears the window, filter, timing and config registers to zero
// depends on afskd_pkg, afskd_ctrl and afskd_dp
`default_nettype none
module afsk_bit_demodulator (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  wire                             in_valid_i,
  output logic                            in_stall_o,
  input  afskd_pkg::in_item_t             in_data_i,
  output logic                            out_valid_o,
  input  wire                             out_stall_i,
  output afskd_pkg::out_item_t            out_data_o,
  input  wire                             cfg_we_i,
  input  wire [afskd_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire [afskd_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  afskd_pkg::dp_cmd_t    cmd;
  afskd_pkg::dp_status_t status;

  afskd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  afskd_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_data_i   (in_data_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

endmodule
`default_nettype wire
